>>> hdl/bse_pkg.sv
// Shared types and constants for the Burning Ship escape-time block.
// No dependencies; imported by bse_cell and burning_ship_escape_time_top.
package bse_pkg;

  // Fixed-point format and field widths.
  localparam int Q_FRAC     = 28;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 8;
  localparam int PIX_W      = 12;
  localparam int PROD_MAP_W = PIX_W + STEP_W;

  // Multiplier chain: CELL_COUNT cells, each retiring one DIGIT_W-bit digit.
  localparam int MUL_W      = 32;
  localparam int DIGIT_W    = 8;
  localparam int CELL_COUNT = MUL_W / DIGIT_W;
  localparam int ACC_W      = 2 * MUL_W;
  localparam int PROD_W     = MUL_W + DIGIT_W;
  localparam int ACC_SHIFT  = ACC_W - PROD_W;

  // |z|^2 >= 4 in Q8.56 means any bit at or above this position is set.
  localparam int ESC_BIT    = 2 * Q_FRAC + 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_RE  = 2'd0,
    CFG_ORIGIN_IM  = 2'd1,
    CFG_PIXEL_STEP = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_COORD,
    ST_ISSUE,
    ST_WAIT,
    ST_FIN
  } state_t;

  // Data handed from one multiplier cell to the next.
  typedef struct packed {
    logic             valid;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
    logic [MUL_W-1:0] a_m;
    logic [MUL_W-1:0] b_m;
    logic [ACC_W-1:0] aa;
    logic [ACC_W-1:0] bb;
    logic [ACC_W-1:0] ab;
  } mul_t;

endpackage

>>> hdl/bse_cell.sv
// One cell of the digit-serial multiplier chain: retires one multiplier digit
// of |z_re|^2, |z_im|^2 and |z_re||z_im|. Depends on bse_pkg.
module bse_cell
  import bse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  mul_t cell_in,
  output mul_t cell_out
);

  logic              valid_r;
  mul_t              data_r;
  mul_t              data_nxt;
  logic [DIGIT_W-1:0] digit_a;
  logic [DIGIT_W-1:0] digit_b;
  logic [PROD_W-1:0]  prod_aa;
  logic [PROD_W-1:0]  prod_bb;
  logic [PROD_W-1:0]  prod_ab;

  // Partial products of the low digit, added above the right-shifted sums.
  always_comb begin
    digit_a = cell_in.a_m[DIGIT_W-1:0];
    digit_b = cell_in.b_m[DIGIT_W-1:0];
    prod_aa = PROD_W'(cell_in.a) * PROD_W'(digit_a);
    prod_bb = PROD_W'(cell_in.b) * PROD_W'(digit_b);
    prod_ab = PROD_W'(cell_in.a) * PROD_W'(digit_b);

    data_nxt       = cell_in;
    data_nxt.a_m   = cell_in.a_m >> DIGIT_W;
    data_nxt.b_m   = cell_in.b_m >> DIGIT_W;
    data_nxt.aa    = (cell_in.aa >> DIGIT_W) + {prod_aa, {ACC_SHIFT{1'b0}}};
    data_nxt.bb    = (cell_in.bb >> DIGIT_W) + {prod_bb, {ACC_SHIFT{1'b0}}};
    data_nxt.ab    = (cell_in.ab >> DIGIT_W) + {prod_ab, {ACC_SHIFT{1'b0}}};
  end

  // The valid bit is control state; the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_comb begin
    cell_out       = data_r;
    cell_out.valid = valid_r;
  end

endmodule

>>> hdl/burning_ship_escape_time_top.sv
// Burning Ship escape-time evaluator, top level with sequencer and config.
// Depends on bse_pkg and bse_cell.
//
// One pixel is worked on at a time; start is taken while busy is low. A
// pixel maps to c = origin + pixel * pixel_step, then each iteration sends
// |z_re| and |z_im| through a chain of four multiplier cells (one 8-bit
// digit per cell): a pass is one issue state and four cells, with the
// escape test and the update made as the last cell's sums arrive. The
// sequencer runs ST_MAP, ST_COORD, then ST_ISSUE and ST_WAIT per pass,
// then ST_FIN, from which out_valid is registered; busy is already low
// while out_valid is high. The pass count is the iteration count plus one
// when the pixel stops on the magnitude test or the limit, equals the count
// on a component overflow, and is zero when the coordinate overflows. The
// receiver cannot stall, so the result is present in the strobe cycle only.
module burning_ship_escape_time_top
  import bse_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration port.
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  // Input transaction.
  input  logic                      start,
  output logic                      busy,
  input  logic [PIX_W-1:0]          in_pixel_x,
  input  logic [PIX_W-1:0]          in_pixel_y,
  // Result transaction.
  output logic                      out_valid,
  output logic [ITER_W-1:0]         out_iteration_count,
  output logic signed [COORD_W-1:0] out_final_sum,
  output logic                      out_escaped
);

  localparam int CSUM_W = PROD_MAP_W + 2;
  localparam int WIDE_W = 39;
  localparam logic [PIX_W-1:0] X_LAST = PIX_W'(MAX_WIDTH - 1);
  localparam logic [PIX_W-1:0] Y_LAST = PIX_W'(MAX_HEIGHT - 1);

  // Saturate a wide signed value to Q4.28.
  function automatic logic [COORD_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic [COORD_W-1:0] res;
    if (v > WIDE_W'(signed'(32'h7FFF_FFFF))) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -WIDE_W'(signed'(33'sh0_8000_0000))) begin
      res = 32'h8000_0000;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  // True when a wide signed value lies outside the Q4.28 range.
  function automatic logic ovf_q(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_W:0] top;
    top = v[WIDE_W-1:COORD_W-1];
    return !((&top) || !(|top));
  endfunction

  // Configuration registers.
  logic [COORD_W-1:0] origin_re_r;
  logic [COORD_W-1:0] origin_im_r;
  logic [STEP_W-1:0]  pixel_step_r;
  logic [ITER_W-1:0]  max_iter_r;

  // Sequencer and datapath registers.
  state_t                  state_r, state_nxt;
  logic [PIX_W-1:0]        px_r, py_r;
  logic [PROD_MAP_W-1:0]   prod_re_r, prod_im_r;
  logic [COORD_W-1:0]      c_re_r, c_im_r;
  logic [COORD_W-1:0]      z_re_r, z_im_r;
  logic [ITER_W-1:0]       count_r;
  logic                    esc_r;
  logic                    out_valid_r;
  logic [ITER_W-1:0]       res_count_r;
  logic [COORD_W-1:0]      res_sum_r;
  logic                    res_esc_r;

  // Combinational signals.
  logic                    issue;
  logic [PIX_W-1:0]        px_clamp, py_clamp;
  logic signed [CSUM_W-1:0] c_re_sum, c_im_sum;
  logic                    coord_ovf;
  logic [MUL_W-1:0]        abs_re, abs_im;
  mul_t                    chain_s [CELL_COUNT+1];
  logic [CELL_COUNT-1:0]   cell_valid;
  mul_t                    chain_out;
  logic [ACC_W:0]          mag_sum;
  logic                    mag_esc;
  logic                    at_limit;
  logic signed [WIDE_W-1:0] z_re_new, z_im_new;
  logic                    iter_ovf;
  logic signed [WIDE_W-1:0] final_wide;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r  <= 32'hE000_0000;
      origin_im_r  <= 32'hE000_0000;
      pixel_step_r <= 31'd1048576;
      max_iter_r   <= 8'd64;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_RE:  origin_re_r  <= cfg_data;
        CFG_ORIGIN_IM:  origin_im_r  <= cfg_data;
        CFG_PIXEL_STEP: pixel_step_r <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER:   max_iter_r   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel clamp and coordinate sums.
  always_comb begin
    px_clamp = (in_pixel_x > X_LAST) ? X_LAST : in_pixel_x;
    py_clamp = (in_pixel_y > Y_LAST) ? Y_LAST : in_pixel_y;
    c_re_sum = CSUM_W'(signed'(origin_re_r)) + signed'({2'b00, prod_re_r});
    c_im_sum = CSUM_W'(signed'(origin_im_r)) + signed'({2'b00, prod_im_r});
    coord_ovf = !((&c_re_sum[CSUM_W-1:COORD_W-1]) || !(|c_re_sum[CSUM_W-1:COORD_W-1]))
             || !((&c_im_sum[CSUM_W-1:COORD_W-1]) || !(|c_im_sum[CSUM_W-1:COORD_W-1]));
  end

  // Magnitudes of the current iterate feed the first cell.
  always_comb begin
    abs_re = z_re_r[COORD_W-1] ? MUL_W'(-z_re_r) : z_re_r;
    abs_im = z_im_r[COORD_W-1] ? MUL_W'(-z_im_r) : z_im_r;
    chain_s[0]       = '0;
    chain_s[0].valid = issue;
    chain_s[0].a     = abs_re;
    chain_s[0].b     = abs_im;
    chain_s[0].a_m   = abs_re;
    chain_s[0].b_m   = abs_im;
  end

  // Row of multiplier cells.
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    bse_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain_s[k]),
      .cell_out (chain_s[k+1])
    );
    assign cell_valid[k] = chain_s[k+1].valid;
  end

  assign chain_out = chain_s[CELL_COUNT];

  // Escape test and next iterate from the finished products.
  always_comb begin
    mag_sum  = {1'b0, chain_out.aa} + {1'b0, chain_out.bb};
    mag_esc  = |mag_sum[ACC_W:ESC_BIT];
    at_limit = count_r >= max_iter_r;
    z_re_new = signed'(WIDE_W'(chain_out.aa[ACC_W-1:Q_FRAC]))
             - signed'(WIDE_W'(chain_out.bb[ACC_W-1:Q_FRAC]))
             + WIDE_W'(signed'(c_re_r));
    z_im_new = signed'(WIDE_W'(chain_out.ab[ACC_W-1:Q_FRAC-1]))
             + WIDE_W'(signed'(c_im_r));
    iter_ovf = ovf_q(z_re_new) || ovf_q(z_im_new);
    final_wide = WIDE_W'(signed'(z_re_r)) + WIDE_W'(signed'(z_im_r));
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = ST_COORD;
      ST_COORD: state_nxt = coord_ovf ? ST_FIN : ST_ISSUE;
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (chain_out.valid) begin
          state_nxt = (mag_esc || at_limit || iter_ovf) ? ST_FIN : ST_ISSUE;
        end
      end
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state_r)
      ST_IDLE:  busy  = 1'b0;
      ST_ISSUE: issue = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r <= px_clamp;
        py_r <= py_clamp;
      end
      ST_MAP: begin
        prod_re_r <= PROD_MAP_W'(px_r) * PROD_MAP_W'(pixel_step_r);
        prod_im_r <= PROD_MAP_W'(py_r) * PROD_MAP_W'(pixel_step_r);
      end
      ST_COORD: begin
        c_re_r  <= c_re_sum[COORD_W-1:0];
        c_im_r  <= c_im_sum[COORD_W-1:0];
        z_re_r  <= '0;
        z_im_r  <= '0;
        count_r <= '0;
        esc_r   <= coord_ovf;
      end
      ST_WAIT: begin
        if (chain_out.valid) begin
          if (mag_esc) begin
            esc_r <= 1'b1;
          end else if (!at_limit) begin
            z_re_r  <= sat_q(z_re_new);
            z_im_r  <= sat_q(z_im_new);
            count_r <= count_r + 1'b1;
            esc_r   <= iter_ovf;
          end
        end
      end
      ST_FIN: begin
        res_count_r <= count_r;
        res_sum_r   <= sat_q(final_wide);
        res_esc_r   <= esc_r;
      end
      default: ;
    endcase
  end

  // One-cycle result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_FIN);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = res_count_r;
  assign out_final_sum       = signed'(res_sum_r);
  assign out_escaped         = res_esc_r;

  // Only one pass is ever in flight in the chain.
  a_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_valid))
    else $error("more than one multiplier cell holds a pass");

  // Finished products arrive only while the sequencer waits for them.
  a_out_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    chain_out.valid |-> (state_r == ST_WAIT))
    else $error("multiplier chain finished outside the wait state");

  // The count never runs past the limit while iterating.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (count_r <= max_iter_r))
    else $error("iteration count exceeded the limit");

  // A strobe follows the finishing cycle and nothing else.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_FIN))
    else $error("result strobe without a finished transaction");

  // An accepted transaction makes the block busy at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule
